>>> rtl/iec104_pkg.sv
// ----------------------------------------------------------------------------
// iec104_pkg
// Shared constants, codes and types of the IEC 104 receive parser.
// ----------------------------------------------------------------------------
`default_nettype none

package iec104_pkg;

   // Frame layout
   localparam logic [7:0] START_BYTE        = 8'h68;
   localparam logic [7:0] MAX_APDU_LEN      = 8'd253;
   localparam logic [7:0] POS_CLASSIFY      = 8'd5;
   localparam logic [7:0] POS_DECODE        = 8'd9;
   localparam logic [7:0] FIRST_OBJ_POS     = 8'd12;
   localparam logic [7:0] FIRST_SEQ_OBJ_POS = 8'd15;
   localparam logic [7:0] POS_MAX           = 8'd255;
   localparam int         HDR_BYTES         = 9;

   // ASDU codes
   localparam logic [7:0]  TYPE_SINGLE = 8'd1;
   localparam logic [7:0]  TYPE_FLOAT  = 8'd13;
   localparam logic [15:0] COT_SPONT   = 16'd3;
   localparam logic [15:0] COT_INTERRO = 16'd20;

   // Result kinds
   localparam logic [1:0] KIND_SINGLE = 2'd0;
   localparam logic [1:0] KIND_FLOAT  = 2'd1;
   localparam logic [1:0] KIND_REPORT = 2'd2;

   // Frame classes
   localparam logic [1:0] FT_BAD = 2'd0;
   localparam logic [1:0] FT_I   = 2'd1;
   localparam logic [1:0] FT_S   = 2'd2;
   localparam logic [1:0] FT_U   = 2'd3;

   // Default depth of the event queue
   localparam int QUEUE_DEPTH = 4;

   // Object decoding mode
   typedef enum logic [1:0] {
      MODE_NONE   = 2'd0,
      MODE_SINGLE = 2'd1,
      MODE_FLOAT  = 2'd2,
      MODE_SEQ    = 2'd3
   } iec104_mode_type;

   // Everything one byte produces: an optional update and an optional report
   typedef struct packed {
      logic        upd_valid;
      logic [1:0]  upd_kind;
      logic [23:0] upd_address;
      logic [31:0] upd_value;
      logic        rpt_valid;
      logic [1:0]  rpt_frame_type;
      logic [14:0] recv_sequence;
   } iec104_evt_type;

endpackage

`default_nettype wire

>>> rtl/iec104_apdu_rx_parser.sv
// ----------------------------------------------------------------------------
// iec104_apdu_rx_parser
// IEC 60870-5-104 receive-side APDU parser, one byte per clock while full is low.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive req_rx_byte and req_frame_end (high on the frame's
//   last byte) with push; a byte is taken on a clock edge with push high and
//   full low. Bytes of a frame arrive in order, one per clock at full rate.
//   Result channel: while empty is low the oldest result is on the rsp_ ports;
//   it is taken on a clock edge with pop high. Each completed information
//   object gives one update, and the last byte of a frame gives a frame
//   report; rsp_last marks the final result caused by a byte.
//   A result is registered in the event queue when its byte is taken.
//   Throughput: one byte per cycle while full is low. A byte that completes an object and ends
//   the frame gives two results and needs two pops; the event queue of
//   QUEUE_DEPTH entries between parser and result stage absorbs that.
//   Reset clears the parser, the receive sequence and the queue.
//   When the receiver stops popping, the queue fills and full holds off
//   further bytes; no result is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module iec104_apdu_rx_parser #(
   parameter int QUEUE_DEPTH = iec104_pkg::QUEUE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [7:0]   req_rx_byte,
   input  wire logic         req_frame_end,
   input  wire logic         push,
   output logic              full,
   output logic [1:0]        rsp_kind,
   output logic [23:0]       rsp_point_address,
   output logic [31:0]       rsp_point_value,
   output logic [1:0]        rsp_frame_type,
   output logic [14:0]       rsp_recv_sequence,
   output logic              rsp_last,
   output logic              empty,
   input  wire logic         pop
);
   import iec104_pkg::*;

   logic           accept;
   logic           evt_valid;
   iec104_evt_type evt;
   iec104_evt_type head;
   logic           head_done;

   assign accept = push && !full;

   // Parse incoming bytes
   iec104_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .frame_end (req_frame_end),
      .evt       (evt),
      .evt_valid (evt_valid)
   );

   // Buffer events between parser and result stage
   iec104_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr     (evt_valid),
      .wr_evt (evt),
      .full   (full),
      .rd     (head_done),
      .rd_evt (head),
      .empty  (empty)
   );

   // Present results
   iec104_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .head_valid    (!empty),
      .pop           (pop),
      .head_done     (head_done),
      .kind          (rsp_kind),
      .point_address (rsp_point_address),
      .point_value   (rsp_point_value),
      .frame_type    (rsp_frame_type),
      .recv_sequence (rsp_recv_sequence),
      .last          (rsp_last)
   );

endmodule

`default_nettype wire

>>> rtl/iec104_front.sv
// ----------------------------------------------------------------------------
// iec104_front
// Byte parser: tracks the frame position, classifies the APCI, decodes
// information objects and builds one event per byte that has results.
// ----------------------------------------------------------------------------
`default_nettype none

module iec104_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire logic [7:0]                rx_byte,
   input  wire logic                      frame_end,
   output iec104_pkg::iec104_evt_type     evt,
   output logic                           evt_valid
);
   import iec104_pkg::*;

   logic [7:0]      pos_ff, pos_in;
   logic [7:0]      hdr_ff [0:HDR_BYTES-1];
   logic [1:0]      class_ff, class_in;
   logic [14:0]     seq_ff, seq_in;
   logic [6:0]      left_ff, left_in;
   logic [2:0]      idx_ff, idx_in;
   logic [23:0]     addr_ff, addr_in;
   logic [31:0]     val_ff, val_in;
   iec104_mode_type mode_ff, mode_in;

   // Place one byte into a lane of a 24-bit address
   function automatic logic [23:0] put_addr_byte(input logic [23:0] a,
                                                 input logic [1:0] lane,
                                                 input logic [7:0] b);
      logic [23:0] r;
      r = a;
      case (lane)
         2'd0:    r[7:0]   = b;
         2'd1:    r[15:8]  = b;
         2'd2:    r[23:16] = b;
         default: r = a;
      endcase
      return r;
   endfunction

   // Store header bytes as they pass
   always_ff @(posedge clock) begin
      if (accept && pos_ff < 8'(HDR_BYTES)) begin
         hdr_ff[pos_ff[3:0]] <= rx_byte;
      end
   end

   // Parse one byte
   always_comb begin
      logic [15:0]     cot;
      logic [2:0]      last_idx;
      logic [2:0]      vstart;
      logic [2:0]      vlane;
      logic [23:0]     obj_addr;
      pos_in   = pos_ff;
      class_in = class_ff;
      seq_in   = seq_ff;
      left_in  = left_ff;
      idx_in   = idx_ff;
      addr_in  = addr_ff;
      val_in   = val_ff;
      mode_in  = mode_ff;
      evt      = '0;
      cot      = {rx_byte, hdr_ff[8]};
      last_idx = 3'd0;
      vstart   = 3'd0;
      vlane    = 3'd0;
      obj_addr = addr_ff;

      // Classify on the last control byte
      if (pos_ff == POS_CLASSIFY) begin
         class_in = FT_BAD;
         if (hdr_ff[0] == START_BYTE && hdr_ff[1] <= MAX_APDU_LEN) begin
            if (!hdr_ff[2][0] && !hdr_ff[4][0]) begin
               class_in = FT_I;
               seq_in   = {hdr_ff[3], hdr_ff[2][7:1]};
            end else if (hdr_ff[2] == 8'd1 && hdr_ff[3] == 8'd0 && !hdr_ff[4][0]) begin
               class_in = FT_S;
            end else if (hdr_ff[2][1:0] == 2'b11 && hdr_ff[3] == 8'd0 &&
                         hdr_ff[4] == 8'd0 && rx_byte == 8'd0) begin
               class_in = FT_U;
            end
         end
      end

      // Pick the object layout once the cause of transmission is complete
      if (pos_ff == POS_DECODE) begin
         mode_in = MODE_NONE;
         if (hdr_ff[6] == TYPE_SINGLE) begin
            mode_in = MODE_SINGLE;
         end else if (hdr_ff[6] == TYPE_FLOAT) begin
            if (cot == COT_SPONT) begin
               mode_in = MODE_FLOAT;
            end else if (cot == COT_INTERRO) begin
               mode_in = MODE_SEQ;
            end
         end
         left_in = (class_ff == FT_I && mode_in != MODE_NONE) ? hdr_ff[7][6:0] : 7'd0;
         idx_in  = 3'd0;
         addr_in = '0;
         val_in  = '0;
      end

      // Decode object bytes
      if (pos_ff >= FIRST_OBJ_POS && left_ff != 7'd0) begin
         if (mode_ff == MODE_SEQ && pos_ff < FIRST_SEQ_OBJ_POS) begin
            addr_in = put_addr_byte(addr_ff, 2'(pos_ff - FIRST_OBJ_POS), rx_byte);
         end else begin
            case (mode_ff)
               MODE_SINGLE: last_idx = 3'd3;
               MODE_FLOAT:  last_idx = 3'd7;
               default:     last_idx = 3'd4;
            endcase
            vstart = (mode_ff == MODE_SEQ) ? 3'd0 : 3'd3;
            vlane  = idx_ff - vstart;
            if (mode_ff != MODE_SEQ && idx_ff < 3'd3) begin
               addr_in = put_addr_byte((idx_ff == 3'd0) ? 24'd0 : addr_ff,
                                       idx_ff[1:0], rx_byte);
            end
            if (mode_ff != MODE_SINGLE && idx_ff >= vstart && vlane < 3'd4) begin
               if (idx_ff == vstart) begin
                  val_in = {24'd0, rx_byte};
               end else begin
                  val_in[8*vlane[1:0] +: 8] = rx_byte;
               end
            end
            if (idx_ff == last_idx) begin
               obj_addr        = addr_in;
               evt.upd_valid   = 1'b1;
               evt.upd_address = obj_addr;
               if (mode_ff == MODE_SINGLE) begin
                  evt.upd_kind  = KIND_SINGLE;
                  evt.upd_value = {24'd0, rx_byte};
               end else begin
                  evt.upd_kind  = KIND_FLOAT;
                  evt.upd_value = val_in;
               end
               left_in = left_ff - 7'd1;
               idx_in  = 3'd0;
               if (mode_ff == MODE_SEQ) begin
                  addr_in = obj_addr + 24'd1;
               end
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
      end

      // Report and restart on the frame's last byte
      if (frame_end) begin
         evt.rpt_valid      = 1'b1;
         evt.rpt_frame_type = (pos_ff >= POS_CLASSIFY) ? class_in : FT_BAD;
         pos_in   = 8'd0;
         class_in = FT_BAD;
         left_in  = 7'd0;
         idx_in   = 3'd0;
         addr_in  = '0;
         val_in   = '0;
      end else if (pos_ff != POS_MAX) begin
         pos_in = pos_ff + 8'd1;
      end

      evt.recv_sequence = seq_in;
      evt_valid = accept && (evt.upd_valid || evt.rpt_valid);
   end

   // Advance parser state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 8'd0;
         class_ff <= FT_BAD;
         seq_ff   <= 15'd0;
         left_ff  <= 7'd0;
         idx_ff   <= 3'd0;
         addr_ff  <= '0;
         val_ff   <= '0;
         mode_ff  <= MODE_NONE;
      end else if (accept) begin
         pos_ff   <= pos_in;
         class_ff <= class_in;
         seq_ff   <= seq_in;
         left_ff  <= left_in;
         idx_ff   <= idx_in;
         addr_ff  <= addr_in;
         val_ff   <= val_in;
         mode_ff  <= mode_in;
      end
   end

   // Objects are only counted for I frames with a known layout
   assert property (@(posedge clock) disable iff (reset)
      left_ff != 7'd0 |-> mode_ff != MODE_NONE && class_ff == FT_I)
      else $error("objects pending without a decodable I frame");

   // Outside float mode, the object byte index never exceeds 4
   assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_FLOAT && left_ff != 7'd0 |-> idx_ff <= 3'd4)
      else $error("object byte index out of range");

endmodule

`default_nettype wire

>>> rtl/iec104_queue.sv
// ----------------------------------------------------------------------------
// iec104_queue
// Small event queue between the parser and the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module iec104_queue #(
   parameter int DEPTH = iec104_pkg::QUEUE_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      wr,
   input  iec104_pkg::iec104_evt_type     wr_evt,
   output logic                           full,
   input  wire logic                      rd,
   output iec104_pkg::iec104_evt_type     rd_evt,
   output logic                           empty
);
   import iec104_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   iec104_evt_type entry_ff [0:DEPTH-1];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;

   assign full   = (count_ff == CW'(DEPTH));
   assign empty  = (count_ff == '0);
   assign rd_evt = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr && !rd) begin
         count_in = count_ff + 1'b1;
      end else if (rd && !wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store written events
   always_ff @(posedge clock) begin
      if (wr) begin
         entry_ff[wr_ptr_ff] <= wr_evt;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(DEPTH))
      else $error("queue occupancy above depth");

   assert property (@(posedge clock) disable iff (reset) wr |-> !full || rd)
      else $error("write into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      wr && !rd |=> count_ff == CW'($past(count_ff) + 1'b1))
      else $error("queue count did not follow a write");

endmodule

`default_nettype wire

>>> rtl/iec104_back.sv
// ----------------------------------------------------------------------------
// iec104_back
// Result stage: turns each queued event into one or two result items.
// ----------------------------------------------------------------------------
`default_nettype none

module iec104_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  iec104_pkg::iec104_evt_type     head,
   input  wire logic                      head_valid,
   input  wire logic                      pop,
   output logic                           head_done,
   output logic [1:0]                     kind,
   output logic [23:0]                    point_address,
   output logic [31:0]                    point_value,
   output logic [1:0]                     frame_type,
   output logic [14:0]                    recv_sequence,
   output logic                           last
);
   import iec104_pkg::*;

   // High once the update of the head event has been taken
   logic upd_sent_ff, upd_sent_in;
   logic show_upd;

   assign show_upd = head.upd_valid && !upd_sent_ff;

   // Select the current result of the head event
   always_comb begin
      recv_sequence = head.recv_sequence;
      if (show_upd) begin
         kind          = head.upd_kind;
         point_address = head.upd_address;
         point_value   = head.upd_value;
         frame_type    = FT_I;
         last          = !head.rpt_valid;
      end else begin
         kind          = KIND_REPORT;
         point_address = '0;
         point_value   = '0;
         frame_type    = head.rpt_frame_type;
         last          = 1'b1;
      end
      head_done   = head_valid && pop && last;
      upd_sent_in = upd_sent_ff;
      if (head_valid && pop) begin
         upd_sent_in = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_sent_ff <= 1'b0;
      end else begin
         upd_sent_ff <= upd_sent_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      head_valid && kind == KIND_REPORT |-> last)
      else $error("frame report not marked last");

   assert property (@(posedge clock) disable iff (reset)
      upd_sent_ff |-> head_valid && head.upd_valid && head.rpt_valid)
      else $error("update marked sent without a pending report");

endmodule

`default_nettype wire

>>> test/iec104_apdu_rx_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iec104_apdu_rx_parser_tb
// Self-checking testbench of the IEC 104 receive-side APDU parser.
// ----------------------------------------------------------------------------
// Bytes of directed and random APDUs (I, S, U, bad header, short, truncated,
// oversized and noise frames) are pushed with random gaps. Results are popped
// with random stalls. Every accepted byte goes through a behavioral decoder
// that predicts the updates and frame reports. Each popped result is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module iec104_apdu_rx_parser_tb;
   import iec104_pkg::*;

   localparam int RANDOM_BYTES = 1750;

   typedef struct {
      logic [1:0]  kind;
      logic [23:0] address;
      logic [31:0] value;
      logic [1:0]  frame_type;
      logic [14:0] seq_num;
      logic        last;
   } apdu_result_type;

   // -------------------------------------------------------------------------
   // Decoder model: tracks frame state and holds the results still due
   // -------------------------------------------------------------------------
   class apdu_update_tracker_type;
      logic [7:0]  byte_pos;
      logic [7:0]  hdr [10];
      logic [1:0]  frame_class;
      logic [14:0] recv_seq;
      logic [7:0]  objs_left;
      logic [2:0]  obj_idx;
      logic [23:0] obj_addr;
      logic [31:0] value_acc;
      apdu_result_type due_updates[$];
      int errors;
      int seen_single;
      int seen_float;
      int seen_report;

      function new();
         int i;
         for (i = 0; i < 10; i++) hdr[i] = 8'h00;
         recv_seq = 15'd0;
         errors = 0;
         seen_single = 0;
         seen_float = 0;
         seen_report = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         byte_pos = 8'd0;
         frame_class = FT_BAD;
         objs_left = 8'd0;
         obj_idx = 3'd0;
         obj_addr = 24'd0;
         value_acc = 32'd0;
      endfunction

      function iec104_mode_type object_mode();
         logic [15:0] cot;
         cot = {hdr[9], hdr[8]};
         if (hdr[6] == TYPE_SINGLE) return MODE_SINGLE;
         if (hdr[6] == TYPE_FLOAT && cot == COT_SPONT) return MODE_FLOAT;
         if (hdr[6] == TYPE_FLOAT && cot == COT_INTERRO) return MODE_SEQ;
         return MODE_NONE;
      endfunction

      // Class the frame from start, length and the four control bytes
      function void classify_frame();
         frame_class = FT_BAD;
         if (hdr[0] != START_BYTE || hdr[1] > MAX_APDU_LEN) return;
         if (!hdr[2][0] && !hdr[4][0]) begin
            frame_class = FT_I;
            recv_seq = {hdr[3], hdr[2][7:1]};
         end else if (hdr[2] == 8'h01 && hdr[3] == 8'h00 && !hdr[4][0]) begin
            frame_class = FT_S;
         end else if (hdr[2][1:0] == 2'b11 && hdr[3] == 8'h00 && hdr[4] == 8'h00 &&
                      hdr[5] == 8'h00) begin
            frame_class = FT_U;
         end
      endfunction

      // Advance the decoder by one accepted byte and queue what it causes
      function void note_byte(logic [7:0] b, logic frame_end);
         logic [7:0]      pos;
         iec104_mode_type m;
         int              idx;
         int              vstart;
         int              size;
         bit              has_update;
         apdu_result_type update;
         apdu_result_type report;
         pos = byte_pos;
         has_update = 1'b0;
         if (pos < 10) hdr[pos] = b;
         if (pos == POS_CLASSIFY) classify_frame();
         if (pos == POS_DECODE) begin
            m = object_mode();
            objs_left = (frame_class == FT_I && m != MODE_NONE) ? {1'b0, hdr[7][6:0]} : 8'd0;
            obj_idx = 3'd0;
            obj_addr = 24'd0;
            value_acc = 32'd0;
         end

         if (pos >= FIRST_OBJ_POS && objs_left != 8'd0) begin
            m = object_mode();
            if (m == MODE_SEQ && pos < FIRST_SEQ_OBJ_POS) begin
               // collect the shared start address of a sequential reply
               obj_addr = obj_addr | ({16'h0000, b} << (8 * (pos - FIRST_OBJ_POS)));
            end else begin
               idx = int'(obj_idx);
               vstart = (m == MODE_SEQ) ? 0 : 3;
               size = (m == MODE_SINGLE) ? 4 : (m == MODE_FLOAT) ? 8 : 5;
               if (m != MODE_SEQ && idx < 3) begin
                  if (idx == 0) obj_addr = 24'd0;
                  obj_addr = obj_addr | ({16'h0000, b} << (8 * idx));
               end
               if (m != MODE_SINGLE && idx >= vstart && idx < vstart + 4) begin
                  if (idx == vstart) value_acc = 32'd0;
                  value_acc = value_acc | ({24'h000000, b} << (8 * (idx - vstart)));
               end
               if (idx + 1 >= size) begin
                  // object complete: emit its update
                  has_update = 1'b1;
                  update.kind = (m == MODE_SINGLE) ? KIND_SINGLE : KIND_FLOAT;
                  update.address = obj_addr;
                  update.value = (m == MODE_SINGLE) ? {24'h000000, b} : value_acc;
                  update.frame_type = FT_I;
                  update.seq_num = recv_seq;
                  update.last = 1'b0;
                  objs_left = objs_left - 8'd1;
                  obj_idx = 3'd0;
                  if (m == MODE_SEQ) obj_addr = obj_addr + 24'd1;
               end else begin
                  obj_idx = 3'(idx + 1);
               end
            end
         end

         if (frame_end) begin
            report.kind = KIND_REPORT;
            report.address = 24'd0;
            report.value = 32'd0;
            report.frame_type = (pos >= POS_CLASSIFY) ? frame_class : FT_BAD;
            report.seq_num = recv_seq;
            report.last = 1'b1;
            if (has_update) due_updates.push_back(update);
            due_updates.push_back(report);
            clear_frame();
         end else begin
            if (byte_pos < POS_MAX) byte_pos = byte_pos + 8'd1;
            if (has_update) begin
               update.last = 1'b1;
               due_updates.push_back(update);
            end
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      // Compare one popped result with the oldest prediction
      function void check_result(apdu_result_type got);
         apdu_result_type want;
         if (due_updates.size() == 0) begin
            $error("result with nothing due: kind %0d address 0x%0h value 0x%0h",
                   got.kind, got.address, got.value);
            errors++;
            return;
         end
         want = due_updates.pop_front();
         compare_field("kind", want.kind, got.kind);
         compare_field("point_address", want.address, got.address);
         compare_field("point_value", want.value, got.value);
         compare_field("frame_type", want.frame_type, got.frame_type);
         compare_field("recv_sequence", want.seq_num, got.seq_num);
         compare_field("last", want.last, got.last);
         if (want.kind == KIND_SINGLE) seen_single++;
         else if (want.kind == KIND_FLOAT) seen_float++;
         else seen_report++;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, ports and block under test
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_frame_end = 1'b0;
   logic        push = 1'b0;
   logic        full;
   logic [1:0]  rsp_kind;
   logic [23:0] rsp_point_address;
   logic [31:0] rsp_point_value;
   logic [1:0]  rsp_frame_type;
   logic [14:0] rsp_recv_sequence;
   logic        rsp_last;
   logic        empty;
   logic        pop = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   iec104_apdu_rx_parser uut (
      .clock             (clock),
      .reset             (reset),
      .req_rx_byte       (req_rx_byte),
      .req_frame_end     (req_frame_end),
      .push              (push),
      .full              (full),
      .rsp_kind          (rsp_kind),
      .rsp_point_address (rsp_point_address),
      .rsp_point_value   (rsp_point_value),
      .rsp_frame_type    (rsp_frame_type),
      .rsp_recv_sequence (rsp_recv_sequence),
      .rsp_last          (rsp_last),
      .empty             (empty),
      .pop               (pop)
   );

   apdu_update_tracker_type tracker = new();

   logic [7:0] frame_buf[$];
   int         bytes_sent = 0;
   int         frames_sent = 0;
   bit         sender_steady = 1'b0;
   int         pop_hold = 0;
   int         pop_steady = 0;
   int         pop_roll;

   // -------------------------------------------------------------------------
   // Result side: stall pop at random, with stretches of steady popping
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (pop_hold > 0) begin
         pop <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else begin
         pop <= 1'b1;
         if (pop_steady > 0) begin
            pop_steady <= pop_steady - 1;
         end else begin
            pop_roll = $urandom_range(0, 99);
            if (pop_roll < 3) pop_steady <= $urandom_range(40, 150);
            else if (pop_roll < 50) pop_hold <= 0;
            else if (pop_roll < 88) pop_hold <= $urandom_range(1, 3);
            else if (pop_roll < 97) pop_hold <= $urandom_range(4, 12);
            else pop_hold <= $urandom_range(30, 80);
         end
      end
   end

   // Check every result taken by the handshake
   always @(posedge clock) begin
      apdu_result_type got;
      if (!reset && pop && !empty) begin
         got.kind = rsp_kind;
         got.address = rsp_point_address;
         got.value = rsp_point_value;
         got.frame_type = rsp_frame_type;
         got.seq_num = rsp_recv_sequence;
         got.last = rsp_last;
         tracker.check_result(got);
      end
   end

   // -------------------------------------------------------------------------
   // Input side
   // -------------------------------------------------------------------------
   function automatic int sender_gap();
      int roll;
      if (sender_steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Offer one byte after a random gap and hold it until full lets it in
   task automatic send_byte(input logic [7:0] b, input logic frame_end);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_rx_byte <= b;
      req_frame_end <= frame_end;
      @(posedge clock);
      while (full) @(posedge clock);
      tracker.note_byte(b, frame_end);
      bytes_sent++;
   endtask

   task automatic send_frame();
      int i;
      sender_steady = ($urandom_range(0, 99) < 15);
      for (i = 0; i < frame_buf.size(); i++) send_byte(frame_buf[i], i == frame_buf.size() - 1);
      frames_sent++;
   endtask

   // Hold off the sender until every predicted result has been popped
   task automatic drain_results();
      push <= 1'b0;
      @(posedge clock);
      while (tracker.due_updates.size() != 0) @(posedge clock);
   endtask

   task automatic add_random_bytes(input int count);
      int i;
      for (i = 0; i < count; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
   endtask

   // I frame with an ASDU; mostly decodable, sometimes cut short or padded
   task automatic build_i_frame(input bit long_frame);
      logic [7:0]  ctrl;
      logic [7:0]  asdu_type;
      logic [7:0]  vsq;
      logic [15:0] cot;
      int          roll;
      int          top;
      int          count;
      int          body;
      top = long_frame ? 7 : 9;
      roll = $urandom_range(0, top);
      asdu_type = (roll < 4) ? TYPE_SINGLE : (roll < 8) ? TYPE_FLOAT :
                  8'($urandom_range(0, 255));
      roll = $urandom_range(0, top);
      cot = (roll < 4) ? COT_SPONT : (roll < 8) ? COT_INTERRO : 16'($urandom_range(0, 65535));
      if (long_frame) count = $urandom_range(62, 127);
      else if ($urandom_range(0, 9) == 0) count = $urandom_range(0, 12);
      else count = $urandom_range(1, 4);
      vsq = 8'(count);
      vsq[7] = 1'($urandom_range(0, 1));

      if (asdu_type == TYPE_SINGLE) body = 4 * count;
      else if (asdu_type == TYPE_FLOAT && cot == COT_SPONT) body = 8 * count;
      else if (asdu_type == TYPE_FLOAT && cot == COT_INTERRO) body = 3 + 5 * count;
      else body = $urandom_range(0, 8);

      frame_buf.push_back(START_BYTE);
      frame_buf.push_back(8'($urandom_range(0, MAX_APDU_LEN)));
      ctrl = 8'($urandom_range(0, 255));
      ctrl[0] = 1'b0;
      frame_buf.push_back(ctrl);
      frame_buf.push_back(8'($urandom_range(0, 255)));
      ctrl = 8'($urandom_range(0, 255));
      ctrl[0] = 1'b0;
      frame_buf.push_back(ctrl);
      frame_buf.push_back(8'($urandom_range(0, 255)));
      frame_buf.push_back(asdu_type);
      frame_buf.push_back(vsq);
      frame_buf.push_back(cot[7:0]);
      frame_buf.push_back(cot[15:8]);
      add_random_bytes(2 + body);

      // pad with surplus bytes or cut the frame early
      roll = $urandom_range(0, 9);
      if (roll == 7) begin
         add_random_bytes($urandom_range(1, 4));
      end else if (roll >= 8) begin
         count = $urandom_range(1, frame_buf.size());
         while (frame_buf.size() > count) void'(frame_buf.pop_back());
      end
   endtask

   task automatic build_random_frame(input bit long_frame);
      logic [7:0] ctrl;
      int         roll;
      frame_buf.delete();
      roll = long_frame ? 0 : $urandom_range(0, 99);
      if (roll < 62) begin
         build_i_frame(long_frame);
      end else if (roll < 72) begin
         // S frame, sometimes with broken control bytes
         frame_buf.push_back(START_BYTE);
         frame_buf.push_back(8'd4);
         frame_buf.push_back(8'h01);
         frame_buf.push_back(8'h00);
         ctrl = 8'($urandom_range(0, 255));
         ctrl[0] = 1'b0;
         frame_buf.push_back(ctrl);
         frame_buf.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 3) == 0) frame_buf[$urandom_range(2, 4)] = 8'($urandom_range(0, 255));
         add_random_bytes($urandom_range(0, 2));
      end else if (roll < 80) begin
         // U frame, sometimes with a stray bit in the zero bytes
         frame_buf.push_back(START_BYTE);
         frame_buf.push_back(8'd4);
         ctrl = 8'($urandom_range(0, 255));
         ctrl[1:0] = 2'b11;
         frame_buf.push_back(ctrl);
         frame_buf.push_back(8'h00);
         frame_buf.push_back(8'h00);
         frame_buf.push_back(8'h00);
         if ($urandom_range(0, 3) == 0) frame_buf[$urandom_range(3, 5)] = 8'($urandom_range(0, 255));
         add_random_bytes($urandom_range(0, 2));
      end else if (roll < 88) begin
         // bad start byte or length above the maximum
         if ($urandom_range(0, 1) == 1) begin
            frame_buf.push_back(8'($urandom_range(0, 255)));
            frame_buf.push_back(8'($urandom_range(0, 255)));
         end else begin
            frame_buf.push_back(START_BYTE);
            frame_buf.push_back(8'($urandom_range(MAX_APDU_LEN + 1, 255)));
         end
         add_random_bytes($urandom_range(4, 16));
      end else if (roll < 94) begin
         // frame that ends before the control bytes are complete
         frame_buf.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : START_BYTE);
         add_random_bytes($urandom_range(0, 4));
      end else begin
         add_random_bytes($urandom_range(1, 24));
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int first_random;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // single byte frame of all ones: short frame
      frame_buf = '{8'hFF};
      send_frame();
      // U frame (test frame activation)
      frame_buf = '{START_BYTE, 8'h04, 8'h43, 8'h00, 8'h00, 8'h00};
      send_frame();
      // S frame
      frame_buf = '{START_BYTE, 8'h04, 8'h01, 8'h00, 8'hFE, 8'hFF};
      send_frame();
      // I frame with top send sequence and one single point at the top address
      frame_buf = '{START_BYTE, 8'h0E, 8'hFE, 8'hFF, 8'h00, 8'h00,
                    TYPE_SINGLE, 8'h01, COT_SPONT[7:0], 8'h00, 8'h01, 8'h00,
                    8'hFF, 8'hFF, 8'hFF, 8'h01};
      send_frame();
      drain_results();

      // random frames, one oversized early on, with a full drain now and then
      first_random = bytes_sent;
      while (bytes_sent - first_random < RANDOM_BYTES) begin
         build_random_frame(frames_sent == 9 || $urandom_range(0, 59) == 0);
         send_frame();
         if (frames_sent % 16 == 0) drain_results();
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (tracker.due_updates.size() != 0) begin
         $error("%0d predicted results never arrived", tracker.due_updates.size());
         tracker.errors++;
      end

      $display("Sent %0d bytes in %0d frames.", bytes_sent, frames_sent);
      $display("Checked %0d single-point updates, %0d float updates, %0d frame reports.",
               tracker.seen_single, tracker.seen_float, tracker.seen_report);
      if (tracker.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
